// ===== hdl/vpet_pkg.sv =====
// Shared types, constants and number-format helpers for the volumetric power-law term pipeline.
package vpet_pkg;

  localparam int EXP_W     = 14;
  localparam int SUM_W     = 56;
  localparam int D_W       = 6;
  localparam int K_W       = 5;
  localparam int CBRT_BITS = 22;
  localparam int DIV_STEPS = 33;
  localparam int WV_W      = 40;
  localparam int IN_W      = 200;
  localparam int OUT_W     = 168;

  localparam logic [0:0] REG_COEFF    = 1'b0;
  localparam logic [0:0] REG_EXPONENT = 1'b1;

  // sign, 32-bit mantissa in [2^31, 2^32) or zero, binary exponent
  typedef struct packed {
    logic                    neg;
    logic [31:0]             m;
    logic signed [EXP_W-1:0] e;
  } num_t;

  localparam num_t NUM_ONE   = '{neg: 1'b0, m: 32'h8000_0000, e: EXP_W'(-31)};
  localparam num_t NUM_THIRD = '{neg: 1'b0, m: 32'hAAAA_AAAA, e: EXP_W'(-33)};
  localparam num_t NUM_NINTH = '{neg: 1'b0, m: 32'hE38E_38E3, e: EXP_W'(-35)};

  typedef struct packed {
    logic signed [SUM_W-1:0] energy;
    logic signed [SUM_W-1:0] first;
    logic signed [SUM_W-1:0] second;
    logic [31:0]             coeff;
    logic [D_W-1:0]          d;
    logic [K_W-1:0]          k;
  } side_t;

  typedef struct packed {
    side_t                   sd;
    num_t                    cp;
    num_t                    u;
    num_t                    acc;
    num_t                    pe;
    num_t                    p1;
    num_t                    p2;
    logic signed [EXP_W-1:0] te;
    logic [31:0]             dm;
    logic [31:0]             rem;
    logic [32:0]             q;
    logic signed [WV_W-1:0]  wv;
  } par_t;

  function automatic num_t mk(input logic neg, input logic [63:0] mag, input int e);
    num_t        r;
    int          p;
    logic [63:0] sh;
    r  = '0;
    p  = 0;
    sh = '0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) p = i;
    end
    if (mag != '0) begin
      if (p >= 31) sh = mag >> (p - 31);
      else sh = mag << (31 - p);
      r.neg = neg;
      r.m   = sh[31:0];
      r.e   = EXP_W'(e + p - 31);
    end
    return r;
  endfunction

  function automatic num_t mul(input num_t a, input num_t b);
    num_t        r;
    logic [63:0] p;
    r = '0;
    p = 64'(a.m) * 64'(b.m);
    if (a.m != '0 && b.m != '0) begin
      r.neg = a.neg ^ b.neg;
      if (p[63]) begin
        r.m = p[63:32];
        r.e = a.e + b.e + EXP_W'(32);
      end else begin
        r.m = p[62:31];
        r.e = a.e + b.e + EXP_W'(31);
      end
    end
    return r;
  endfunction

  // truncate toward zero to frac fraction bits, magnitude capped at 2^56
  function automatic logic signed [SUM_W+1:0] to_fixed(input num_t x, input int frac);
    logic [SUM_W:0] mag;
    int             sh;
    sh = int'(x.e) + frac;
    if (x.m == '0) mag = '0;
    else if (sh > SUM_W - 32) mag = (SUM_W+1)'(1) << SUM_W;
    else if (sh >= 0) mag = (SUM_W+1)'(x.m) << sh;
    else if (sh <= -64) mag = '0;
    else mag = (SUM_W+1)'(x.m) >> (-sh);
    if (x.neg) return -$signed({1'b0, mag});
    return $signed({1'b0, mag});
  endfunction

  // msb is the clip flag
  function automatic logic [SUM_W:0] clip_add(input logic [SUM_W-1:0] a,
                                              input logic signed [SUM_W+1:0] f);
    logic [SUM_W+1:0] s;
    logic [SUM_W:0]   r;
    s = {{2{a[SUM_W-1]}}, a} + f;
    if (s[SUM_W+1:SUM_W-1] == 3'b000 || s[SUM_W+1:SUM_W-1] == 3'b111) begin
      r = {1'b0, s[SUM_W-1:0]};
    end else if (s[SUM_W+1]) begin
      r = {1'b1, 1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      r = {1'b1, 1'b0, {(SUM_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== hdl/vpet_cbrt.sv =====
// Pipelined integer cube root, one result bit per stage, with side data carried alongside.
module vpet_cbrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [63:0]                       in_v,
  input  vpet_pkg::side_t                   in_side,
  output logic                              out_valid,
  output logic [vpet_pkg::CBRT_BITS-1:0]    out_y,
  output vpet_pkg::side_t                   out_side
);
  import vpet_pkg::*;

  localparam int N    = CBRT_BITS;
  localparam int Y2_W = 2 * N;
  localparam int C_W  = 3 * N + 2;

  logic              vld_q [1:N];
  logic [63:0]       v_q   [1:N];
  logic [N-1:0]      y_q   [1:N];
  logic [Y2_W-1:0]   y2_q  [1:N];
  logic [63:0]       y3_q  [1:N];
  side_t             sd_q  [1:N];

  genvar i;
  for (i = 0; i < N; i++) begin : g_step
    localparam int B = N - 1 - i;
    logic            cur_v;
    logic [63:0]     cur_x;
    logic [N-1:0]    cur_y;
    logic [Y2_W-1:0] cur_y2;
    logic [63:0]     cur_y3;
    side_t           cur_sd;
    logic [C_W-1:0]  c3;
    logic [Y2_W-1:0] c2;
    logic            take;

    if (i == 0) begin : g_first
      assign cur_v  = in_valid;
      assign cur_x  = in_v;
      assign cur_y  = '0;
      assign cur_y2 = '0;
      assign cur_y3 = '0;
      assign cur_sd = in_side;
    end else begin : g_next
      assign cur_v  = vld_q[i];
      assign cur_x  = v_q[i];
      assign cur_y  = y_q[i];
      assign cur_y2 = y2_q[i];
      assign cur_y3 = y3_q[i];
      assign cur_sd = sd_q[i];
    end

    // (y + 2^B)^3 and (y + 2^B)^2 from running powers
    always_comb begin
      c3 = C_W'(cur_y3) + ((C_W'(3) * C_W'(cur_y2)) << B)
         + ((C_W'(3) * C_W'(cur_y)) << (2 * B)) + (C_W'(1) << (3 * B));
      c2 = cur_y2 + (Y2_W'(cur_y) << (B + 1)) + (Y2_W'(1) << (2 * B));
      take = c3 <= C_W'(cur_x);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i+1] <= 1'b0;
      end else if (en) begin
        vld_q[i+1] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_q[i+1]  <= cur_x;
        sd_q[i+1] <= cur_sd;
        if (take) begin
          y_q[i+1]  <= cur_y | (N'(1) << B);
          y2_q[i+1] <= c2;
          y3_q[i+1] <= c3[63:0];
        end else begin
          y_q[i+1]  <= cur_y;
          y2_q[i+1] <= cur_y2;
          y3_q[i+1] <= cur_y3;
        end
      end
    end
  end

  assign out_valid = vld_q[N];
  assign out_y     = y_q[N];
  assign out_side  = sd_q[N];

endmodule

// ===== hdl/volumetric_power_energy_terms.sv =====
// Volumetric power-law energy term and its first and second I3 derivatives, added to running sums.
// Throughput is one word per cycle while the output is not stalled.
// Depth is set by the 22-stage cube root and the 33-stage reciprocal divider, with the
// power chain on u running beside the divider and a 7-stage product and rounding tail.
// A stalled output holds the whole pipeline. Synchronous reset clears all valid bits and
// sets the coefficient to 0 and the exponent to 2.
module volumetric_power_energy_terms #(
  parameter int FRAC_BITS    = 24,
  parameter int MAX_EXPONENT = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // third_invariant[31:0], energy_in[87:32], first_deriv_in[143:88], second_deriv_in[199:144]
  input  logic [vpet_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // energy_out[55:0], first_deriv_out[111:56], second_deriv_out[167:112]
  output logic [vpet_pkg::OUT_W-1:0]    m_tdata,
  // exponent_error[0], saturated[1]
  output logic [1:0]                    m_tuser,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_addr,
  input  logic [31:0]                   cfg_data
);
  import vpet_pkg::*;

  logic        en;
  logic [31:0] coeff;
  logic [4:0]  pexp;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '0;
      pexp  <= 5'd2;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COEFF:    coeff <= cfg_data;
        REG_EXPONENT: pexp  <= cfg_data[4:0];
        default:      ;
      endcase
    end
  end

  // stage P0: capture
  logic        p0v;
  logic [31:0] p0_x;
  side_t       p0_sd;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_x            <= (s_tdata[31:0] == '0) ? 32'd1 : s_tdata[31:0];
      p0_sd.energy    <= s_tdata[87:32];
      p0_sd.first     <= s_tdata[143:88];
      p0_sd.second    <= s_tdata[199:144];
      p0_sd.coeff     <= coeff;
      p0_sd.d         <= (int'(pexp) > MAX_EXPONENT) ? D_W'(MAX_EXPONENT) : D_W'(pexp);
      p0_sd.k         <= '0;
    end
  end

  // stage P1: scale so the cube root has an integer exponent
  logic        p1v;
  logic [63:0] p1_v;
  side_t       p1_sd;
  side_t       p1_sd_next;
  logic [4:0]  msb;
  logic [6:0]  a0, asum, q3, a_sh;
  logic [11:0] q3_full;
  logic [1:0]  rem3;

  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (p0_x[i]) msb = 5'(i);
    end
    a0      = 7'(63) - 7'(msb);
    asum    = a0 + 7'(FRAC_BITS);
    q3_full = (12'(asum) * 12'd43) >> 7;  // floor(n/3) for n < 128
    q3      = q3_full[6:0];
    rem3    = 2'(asum - 7'(q3 * 7'd3));
    a_sh    = a0 - 7'(rem3);
    p1_sd_next   = p0_sd;
    p1_sd_next.k = K_W'(q3);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_v  <= 64'(p0_x) << a_sh[5:0];
      p1_sd <= p1_sd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0v <= 1'b0;
      p1v <= 1'b0;
    end else if (en) begin
      p0v <= s_tvalid;
      p1v <= p0v;
    end
  end

  logic                 cb_valid;
  logic [CBRT_BITS-1:0] cb_y;
  side_t                cb_sd;

  vpet_cbrt u_cbrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p1v),
    .in_v      (p1_v),
    .in_side   (p1_sd),
    .out_valid (cb_valid),
    .out_y     (cb_y),
    .out_side  (cb_sd)
  );

  // stage Q0: u, t, c, and the (d-3)*t+2 numerator
  logic [33:0]            q_pk, q_dif, q_mag;
  logic                   q_neg, q_cneg;
  logic [32:0]            q_cmag;
  num_t                   q_t, q_u, q_cp;
  logic signed [D_W+1:0]  q_dm3;
  logic signed [WV_W-1:0] q_prod, q_wv;

  always_comb begin
    q_pk   = 34'(1) << cb_sd.k;
    q_dif  = 34'(cb_y) - q_pk;
    q_neg  = q_dif[33];
    q_mag  = q_neg ? (~q_dif + 34'd1) : q_dif;
    q_t    = mk(1'b0, 64'(cb_y), -int'(cb_sd.k));
    q_u    = mk(q_neg, 64'(q_mag), -int'(cb_sd.k));
    q_cneg = cb_sd.coeff[31];
    q_cmag = q_cneg ? (33'h1_0000_0000 - 33'(cb_sd.coeff)) : 33'(cb_sd.coeff);
    q_cp   = mk(q_cneg, 64'(q_cmag), -16);
    q_dm3  = $signed({2'b00, cb_sd.d}) - (D_W+2)'(3);
    q_prod = WV_W'(q_dm3) * WV_W'($signed({1'b0, cb_y}));
    q_wv   = q_prod + $signed(WV_W'(1) << (int'(cb_sd.k) + 1));
  end

  logic pv0;
  par_t par0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv0 <= 1'b0;
    end else if (en) begin
      pv0 <= cb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      par0.sd  <= cb_sd;
      par0.cp  <= q_cp;
      par0.u   <= q_u;
      par0.acc <= NUM_ONE;
      par0.pe  <= (cb_sd.d == D_W'(0)) ? NUM_ONE : '0;
      par0.p1  <= (cb_sd.d == D_W'(1)) ? NUM_ONE : '0;
      par0.p2  <= (cb_sd.d == D_W'(2)) ? NUM_ONE : '0;
      par0.te  <= q_t.e;
      par0.dm  <= q_t.m;
      par0.rem <= 32'h4000_0000;
      par0.q   <= '0;
      par0.wv  <= q_wv;
    end
  end

  // reciprocal divider steps with the u^n chain beside them
  logic pv_q  [1:DIV_STEPS];
  par_t par_q [1:DIV_STEPS];

  genvar i;
  for (i = 0; i < DIV_STEPS; i++) begin : g_par
    localparam int J = i + 1;
    par_t        cur, nx;
    logic        cur_v;
    logic [32:0] rem2;
    num_t        acc;

    if (i == 0) begin : g_first
      assign cur   = par0;
      assign cur_v = pv0;
    end else begin : g_next
      assign cur   = par_q[i];
      assign cur_v = pv_q[i];
    end

    always_comb begin
      nx   = cur;
      rem2 = {cur.rem, 1'b0};
      acc  = mul(cur.acc, cur.u);
      if (rem2 >= {1'b0, cur.dm}) begin
        nx.rem = 32'(rem2 - {1'b0, cur.dm});
        nx.q   = {cur.q[31:0], 1'b1};
      end else begin
        nx.rem = rem2[31:0];
        nx.q   = {cur.q[31:0], 1'b0};
      end
      if (J <= MAX_EXPONENT) begin
        nx.acc = acc;
        if (cur.sd.d == D_W'(J)) nx.pe = acc;
        if (cur.sd.d == D_W'(J + 1)) nx.p1 = acc;
        if (cur.sd.d == D_W'(J + 2)) nx.p2 = acc;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pv_q[J] <= 1'b0;
      end else if (en) begin
        pv_q[J] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        par_q[J] <= nx;
      end
    end
  end

  par_t            pl;
  logic            plv;
  logic [WV_W-1:0] pl_wv_mag;

  assign pl        = par_q[DIV_STEPS];
  assign plv       = pv_q[DIV_STEPS];
  assign pl_wv_mag = pl.wv[WV_W-1] ? WV_W'(-pl.wv) : WV_W'(pl.wv);

  // product tail
  logic [7:1] tv;
  side_t t1_sd, t2_sd, t3_sd, t4_sd, t5_sd, t6_sd, t7_sd;
  num_t  t1_r, t1_e, t1_cd, t1_w, t1_p1, t1_p2;
  num_t  t2_r, t2_r2, t2_cd3, t2_cd9, t2_w, t2_e, t2_p1, t2_p2;
  num_t  t3_f1, t3_wt, t3_r3, t3_r2, t3_r, t3_p2, t3_e;
  num_t  t4_f, t4_s1, t4_r4, t4_r, t4_e;
  num_t  t5_r5, t5_s1, t5_f, t5_e;
  num_t  t6_s, t6_f, t6_e;
  logic signed [SUM_W+1:0] t7_fe, t7_ff, t7_fs;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r   <= mk(1'b0, 64'(pl.q), -63 - int'(pl.te));
      t1_e   <= mul(pl.cp, pl.pe);
      t1_cd  <= mul(pl.cp, mk(1'b0, 64'(pl.sd.d), 0));
      t1_w   <= mk(pl.wv[WV_W-1], 64'(pl_wv_mag), -int'(pl.sd.k));
      t1_p1  <= pl.p1;
      t1_p2  <= pl.p2;
      t1_sd  <= pl.sd;

      t2_r2  <= mul(t1_r, t1_r);
      t2_cd3 <= mul(t1_cd, NUM_THIRD);
      t2_cd9 <= mul(t1_cd, NUM_NINTH);
      t2_r   <= t1_r;
      t2_w   <= t1_w;
      t2_e   <= t1_e;
      t2_p1  <= t1_p1;
      t2_p2  <= t1_p2;
      t2_sd  <= t1_sd;

      t3_f1  <= mul(t2_cd3, t2_p1);
      t3_wt  <= mul(t2_cd9, t2_w);
      t3_r3  <= mul(t2_r2, t2_r);
      t3_r2  <= t2_r2;
      t3_r   <= t2_r;
      t3_p2  <= t2_p2;
      t3_e   <= t2_e;
      t3_sd  <= t2_sd;

      t4_f   <= mul(t3_f1, t3_r2);
      t4_s1  <= mul(t3_wt, t3_p2);
      t4_r4  <= mul(t3_r3, t3_r);
      t4_r   <= t3_r;
      t4_e   <= t3_e;
      t4_sd  <= t3_sd;

      t5_r5  <= mul(t4_r4, t4_r);
      t5_s1  <= t4_s1;
      t5_f   <= t4_f;
      t5_e   <= t4_e;
      t5_sd  <= t4_sd;

      t6_s   <= mul(t5_s1, t5_r5);
      t6_f   <= t5_f;
      t6_e   <= t5_e;
      t6_sd  <= t5_sd;

      t7_fe  <= to_fixed(t6_e, FRAC_BITS);
      t7_ff  <= to_fixed(t6_f, FRAC_BITS);
      t7_fs  <= to_fixed(t6_s, FRAC_BITS);
      t7_sd  <= t6_sd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv       <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      tv       <= {tv[6:1], plv};
      m_tvalid <= tv[7];
    end
  end

  // output word
  logic [SUM_W:0] o_e, o_f, o_s;
  logic           o_err, o_sat;

  always_comb begin
    o_e   = clip_add(t7_sd.energy, t7_fe);
    o_f   = clip_add(t7_sd.first, t7_ff);
    o_s   = clip_add(t7_sd.second, t7_fs);
    o_err = t7_sd.d < D_W'(2);
    o_sat = o_e[SUM_W] || (!o_err && (o_f[SUM_W] || o_s[SUM_W]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {o_err ? t7_sd.second : o_s[SUM_W-1:0],
                  o_err ? t7_sd.first  : o_f[SUM_W-1:0],
                  o_e[SUM_W-1:0]};
      m_tuser <= {o_sat, o_err};
    end
  end

`ifndef SYNTHESIS
  a_rst_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
  a_cbrt_range: assert property (@(posedge clk) disable iff (rst)
    cb_valid |-> (cb_y[CBRT_BITS-1] || cb_y[CBRT_BITS-2]))
    else $error("cube root out of range");
  a_recip_range: assert property (@(posedge clk) disable iff (rst)
    plv |-> (pl.q[32] || pl.q[31]))
    else $error("reciprocal quotient out of range");
  a_err_flag: assert property (@(posedge clk) disable iff (rst)
    (tv[7] && en) |=> (m_tvalid && (m_tuser[0] == ($past(t7_sd.d) < D_W'(2)))))
    else $error("exponent error flag mismatch");
`endif

endmodule

// ===== verif/tb.sv =====
// Streaming testbench for volumetric_power_energy_terms: random and directed words checked against a bit-exact predictor.
`timescale 1ns / 1ps

module tb;
  import vpet_pkg::*;

  typedef struct {
    bit        neg;
    bit [31:0] m;
    int        e;
  } fnum_t;

  typedef struct {
    bit [31:0] inv;
    bit [55:0] en;
    bit [55:0] d1;
    bit [55:0] d2;
  } point_t;

  typedef struct {
    bit [55:0] en;
    bit [55:0] d1;
    bit [55:0] d2;
    bit        err;
    bit        sat;
  } sums_t;

  localparam longint SUM_HI = (64'sd1 <<< 55) - 1;
  localparam longint SUM_LO = -(64'sd1 <<< 55);
  localparam int     MAX_EXP = 16;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0]       m_tuser;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_addr = REG_COEFF;
  logic [31:0]      cfg_data = '0;

  point_t    pending[$];
  sums_t     expected_sums[$];
  bit [31:0] coeff = 32'd0;
  bit [4:0]  expo = 5'd2;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        errors = 0;

  volumetric_power_energy_terms dut (.*);

  always #2 clk = ~clk;

  function automatic fnum_t norm(bit neg, bit [63:0] mag, int e);
    fnum_t r;
    r = '{1'b0, 32'd0, 0};
    if (mag == 0) return r;
    while (mag >= 64'h1_0000_0000) begin
      mag = mag >> 1;
      e++;
    end
    while (mag < 64'h8000_0000) begin
      mag = mag << 1;
      e--;
    end
    r.neg = neg;
    r.m = mag[31:0];
    r.e = e;
    return r;
  endfunction

  function automatic fnum_t fmul(fnum_t a, fnum_t b);
    bit [63:0] p;
    if (a.m == 0 || b.m == 0) return norm(1'b0, 64'd0, 0);
    p = 64'(a.m) * 64'(b.m);
    if (p[63]) return norm(a.neg ^ b.neg, p >> 32, a.e + b.e + 32);
    return norm(a.neg ^ b.neg, p >> 31, a.e + b.e + 31);
  endfunction

  function automatic fnum_t fpow(fnum_t x, int n);
    fnum_t acc;
    acc = norm(1'b0, 64'd1, 0);
    for (int i = 0; i < n; i++) acc = fmul(acc, x);
    return acc;
  endfunction

  function automatic fnum_t from_signed(longint v, int e);
    if (v < 0) return norm(1'b1, 64'(-v), e);
    return norm(1'b0, 64'(v), e);
  endfunction

  function automatic bit [63:0] cube_root(bit [63:0] v);
    bit [63:0] y, c;
    y = 0;
    for (int i = 21; i >= 0; i--) begin
      c = y | (64'd1 << i);
      if (c * c <= v / c) y = c;
    end
    return y;
  endfunction

  function automatic longint as_fixed(fnum_t x);
    bit [63:0] mag;
    int        sh;
    if (x.m == 0) return 0;
    sh = x.e + 24;
    if (sh > 24) mag = 64'd1 << 56;
    else if (sh >= 0) mag = 64'(x.m) << sh;
    else if (sh <= -64) mag = 0;
    else mag = 64'(x.m) >> (-sh);
    return x.neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic bit [55:0] add_clip(bit [55:0] acc, fnum_t term, inout bit sat);
    longint s;
    s = longint'($signed(acc)) + as_fixed(term);
    if (s > SUM_HI) begin
      s = SUM_HI;
      sat = 1'b1;
    end
    if (s < SUM_LO) begin
      s = SUM_LO;
      sat = 1'b1;
    end
    return s[55:0];
  endfunction

  function automatic sums_t predict_sums(point_t p);
    sums_t     r;
    bit [63:0] x, y, cmag;
    int        d, b, a, k;
    longint    wv;
    bit        sat;
    fnum_t     u, t, rc, cp, cd, term;
    x = 64'(p.inv);
    sat = 1'b0;
    if (x == 0) x = 1;
    d = (expo > MAX_EXP) ? MAX_EXP : int'(expo);
    b = 31;
    while (!x[b]) b--;
    a = 63 - b;
    while ((a + 24) % 3 != 0) a--;
    k = (a + 24) / 3;
    y = cube_root(x << a);
    u = from_signed(longint'(y) - (64'sd1 <<< k), -k);
    t = norm(1'b0, y, -k);
    rc = norm(t.neg, (64'd1 << 63) / t.m, -63 - t.e);
    cmag = coeff[31] ? (64'h1_0000_0000 - 64'(coeff)) : 64'(coeff);
    cp = norm(coeff[31], cmag, -16);
    r.en = add_clip(p.en, fmul(cp, fpow(u, d)), sat);
    if (d < 2) begin
      r.d1 = p.d1;
      r.d2 = p.d2;
      r.err = 1'b1;
    end else begin
      cd = fmul(cp, norm(1'b0, 64'(d), 0));
      term = fmul(fmul(fmul(cd, norm(1'b0, 64'h0_AAAA_AAAA, -33)), fpow(u, d - 1)),
                  fmul(rc, rc));
      r.d1 = add_clip(p.d1, term, sat);
      wv = longint'(d - 3) * longint'(y) + (64'sd1 <<< (k + 1));
      term = fmul(fmul(cd, norm(1'b0, 64'h0_E38E_38E3, -35)), from_signed(wv, -k));
      term = fmul(fmul(term, fpow(u, d - 2)), fpow(rc, 5));
      r.d2 = add_clip(p.d2, term, sat);
      r.err = 1'b0;
    end
    r.sat = sat;
    return r;
  endfunction

  task automatic report(string what, bit [55:0] want, bit [55:0] got);
    $display("mismatch %s: expected %h got %h", what, want, got);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
        point_t p;
        p = pending.pop_front();
        s_tdata <= {p.d2, p.d1, p.en, p.inv};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      point_t p;
      p.inv = s_tdata[31:0];
      p.en = s_tdata[87:32];
      p.d1 = s_tdata[143:88];
      p.d2 = s_tdata[199:144];
      expected_sums.push_back(predict_sums(p));
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_sums.size() == 0) begin
        $display("unexpected output word");
        errors++;
      end else begin
        sums_t w;
        w = expected_sums.pop_front();
        if (m_tdata[55:0] != w.en) report("energy_out", w.en, m_tdata[55:0]);
        if (m_tdata[111:56] != w.d1) report("first_deriv_out", w.d1, m_tdata[111:56]);
        if (m_tdata[167:112] != w.d2) report("second_deriv_out", w.d2, m_tdata[167:112]);
        if (m_tuser[0] != w.err) report("exponent_error", 56'(w.err), 56'(m_tuser[0]));
        if (m_tuser[1] != w.sat) report("saturated", 56'(w.sat), 56'(m_tuser[1]));
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, bit [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    if (idx == REG_COEFF) coeff = val;
    else expo = val[4:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (pending.size() > 0 || s_tvalid || expected_sums.size() > 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  function automatic bit [55:0] rand_sum();
    bit [55:0] v;
    case ($urandom_range(5))
      0: v = 56'h7F_FFFF_FFFF_FFFF - 56'($urandom_range(1000));
      1: v = 56'h80_0000_0000_0000 + 56'($urandom_range(1000));
      2: v = 56'($signed($urandom)) <<< $urandom_range(20);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic point_t rand_point();
    point_t p;
    case ($urandom_range(3))
      0: p.inv = 32'h0100_0000 + 32'($signed($urandom_range(4000)) - 2000);
      1: p.inv = $urandom >> $urandom_range(31);
      default: p.inv = $urandom;
    endcase
    p.en = rand_sum();
    p.d1 = rand_sum();
    p.d2 = rand_sum();
    return p;
  endfunction

  initial begin
    bit [31:0] coeffs[8];
    bit [4:0]  expos[8];
    bit [31:0] dir_inv[7];
    point_t    p;
    coeffs = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
               32'hFFFE_8000, 32'h0003_4000, 32'h7FFF_FFFF, 32'h8000_0000};
    expos = '{5'd2, 5'd0, 5'd1, 5'd3, 5'd16, 5'd31, 5'd17, 5'd2};
    dir_inv = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0100_0000, 32'h0100_0001,
                32'h0080_0000, 32'h1000_0000};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset values first: c = 0, d = 2
    for (int i = 0; i < 7; i++) begin
      p = '{dir_inv[i], 56'h7F_FFFF_FFFF_FFFF, 56'h80_0000_0000_0000, 56'h0};
      pending.push_back(p);
    end
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_COEFF, (ph == 3) ? $urandom : coeffs[ph]);
      write_reg(REG_EXPONENT, 32'(expos[ph]));
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      if (ph < 2) begin
        for (int i = 0; i < 7; i++) begin
          p = '{dir_inv[i], 56'h7F_FFFF_FFFF_FFFF, 56'h80_0000_0000_0000,
                56'h7F_FFFF_FFFF_FFFF};
          pending.push_back(p);
        end
      end
      for (int i = 0; i < 110; i++) pending.push_back(rand_point());
      drain();
    end

    if (errors == 0) begin
      $display("volumetric_power_energy_terms test passed");
    end else begin
      $display("volumetric_power_energy_terms test failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("volumetric_power_energy_terms test failed");
    $finish;
  end

endmodule
